@@ rtl/pf_pkg.sv @@
// Shared types and constants for the Playfair digraph cipher core.
package pf_pkg;

   localparam int unsigned CodeWidth = 5;
   localparam int unsigned Side = 5;
   localparam int unsigned CoordWidth = 3;
   localparam int unsigned DataWidth = 32;
   localparam int unsigned AddrWidth = 5;
   localparam int unsigned QueueDepth = 4;

   localparam logic [CodeWidth-1:0] CodeI = 5'd8;
   localparam logic [CodeWidth-1:0] CodeJ = 5'd9;
   localparam logic [CodeWidth-1:0] CodeX = 5'd23;

   // Register indexes of the configuration port (word address).
   localparam logic [2:0] RegKeyRowZero  = 3'd0;
   localparam logic [2:0] RegKeyRowOne   = 3'd1;
   localparam logic [2:0] RegKeyRowTwo   = 3'd2;
   localparam logic [2:0] RegKeyRowThree = 3'd3;
   localparam logic [2:0] RegKeyRowFour  = 3'd4;
   localparam logic [2:0] RegDecryptMode = 3'd5;

   typedef logic [Side-1:0][CodeWidth-1:0] key_row_type;
   typedef key_row_type [Side-1:0] key_square_type;
   typedef logic [CoordWidth-1:0] coord_type;

   // Alphabetic square without J.
   localparam key_square_type KeyReset = '{
      25'd27025109, 25'd21613104, 25'd16201099, 25'd10755269, 25'd4294688
   };

   // One digraph handed from the front end to the back end.
   typedef struct packed {
      logic [CodeWidth-1:0] first;
      logic [CodeWidth-1:0] second;
      logic                 last;
   } job_type;

   // Push side of the job queue.
   typedef struct packed {
      logic    valid;
      job_type job;
   } job_push_type;

endpackage

@@ rtl/pf_queue.sv @@
// Small first-in first-out queue of digraph jobs between front and back end.
module pf_queue #(
   parameter int unsigned Depth = pf_pkg::QueueDepth
) (
   input  logic                 clock,
   input  logic                 reset,
   input  pf_pkg::job_push_type wr,
   output logic                 full,
   input  logic                 pop,
   output pf_pkg::job_type      rd_job,
   output logic                 empty
);
   import pf_pkg::*;

   localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CountWidth = $clog2(Depth + 1);

   job_type                store_ff [Depth];
   logic [PtrWidth-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]  count_ff, count_in;
   logic                   do_push, do_pop;

   assign full  = (count_ff == CountWidth'(Depth));
   assign empty = (count_ff == '0);
   assign do_push = wr.valid && !full;
   assign do_pop  = pop && !empty;
   assign rd_job  = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= wr.job;
      end
   end

endmodule

@@ rtl/pf_front.sv @@
// Front end: folds letters, pairs them into digraphs and queues the digraphs.
module pf_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   output logic                            full,
   input  logic [pf_pkg::CodeWidth-1:0]    req_letter,
   input  logic                            req_message_end,
   output pf_pkg::job_push_type            job_push,
   input  logic                            queue_full
);
   import pf_pkg::*;

   logic                 pending_valid_ff, pending_valid_in;
   logic [CodeWidth-1:0] pending_letter_ff, pending_letter_in;
   logic                 extra_valid_ff, extra_valid_in;
   job_type              extra_job_ff, extra_job_in;
   logic                 accept;
   logic [CodeWidth-1:0] folded;
   logic                 new_valid, new_extra;
   job_type              new_job;

   assign full   = extra_valid_ff || queue_full;
   assign accept = push && !full;
   assign folded = (req_letter == CodeJ) ? CodeI : req_letter;

   // Classify the request against the waiting letter.
   always_comb begin
      new_valid         = 1'b0;
      new_extra         = 1'b0;
      new_job           = '{first: folded, second: CodeX, last: 1'b1};
      extra_job_in      = extra_job_ff;
      pending_valid_in  = pending_valid_ff;
      pending_letter_in = pending_letter_ff;
      if (!pending_valid_ff) begin
         if (req_message_end) begin
            new_valid = 1'b1;
         end else begin
            pending_valid_in  = 1'b1;
            pending_letter_in = folded;
         end
      end else if (pending_letter_ff != folded) begin
         new_valid        = 1'b1;
         new_job.first    = pending_letter_ff;
         new_job.second   = folded;
         pending_valid_in = 1'b0;
      end else begin
         // A doubled letter takes the filler; at message end the copy is flushed too.
         new_valid    = 1'b1;
         new_job.last = !req_message_end;
         if (req_message_end) begin
            new_extra        = 1'b1;
            extra_job_in     = '{first: folded, second: CodeX, last: 1'b1};
            pending_valid_in = 1'b0;
         end
      end
      if (!accept) begin
         pending_valid_in  = pending_valid_ff;
         pending_letter_in = pending_letter_ff;
         extra_job_in      = extra_job_ff;
      end
   end

   always_comb begin
      extra_valid_in = extra_valid_ff;
      if (extra_valid_ff && !queue_full) begin
         extra_valid_in = 1'b0;
      end else if (accept && new_extra) begin
         extra_valid_in = 1'b1;
      end
   end

   always_comb begin
      job_push.valid = (extra_valid_ff || (accept && new_valid)) && !queue_full;
      job_push.job   = extra_valid_ff ? extra_job_ff : new_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_valid_ff  <= 1'b0;
         pending_letter_ff <= '0;
         extra_valid_ff    <= 1'b0;
      end else begin
         pending_valid_ff  <= pending_valid_in;
         pending_letter_ff <= pending_letter_in;
         extra_valid_ff    <= extra_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      extra_job_ff <= extra_job_in;
   end

endmodule

@@ rtl/pf_back.sv @@
// Back end: locates digraph letters in the key square and emits substituted letters.
module pf_back (
   input  logic                         clock,
   input  logic                         reset,
   input  pf_pkg::key_square_type       key_square,
   input  logic                         decrypt_mode,
   input  pf_pkg::job_type              head_job,
   input  logic                         queue_empty,
   output logic                         queue_pop,
   output logic                         empty,
   input  logic                         pop,
   output logic [pf_pkg::CodeWidth-1:0] rsp_out_letter,
   output logic                         rsp_run_end
);
   import pf_pkg::*;

   typedef struct packed {
      coord_type row;
      coord_type col;
   } place_type;

   // Letters missing from the square sit at row 0, column 0; the first cell wins.
   function automatic place_type locate(key_square_type key, logic [CodeWidth-1:0] code);
      place_type place;
      place = '0;
      for (int r = Side - 1; r >= 0; r--) begin
         for (int c = Side - 1; c >= 0; c--) begin
            if (key[r][c] == code) begin
               place.row = CoordWidth'(r);
               place.col = CoordWidth'(c);
            end
         end
      end
      return place;
   endfunction

   function automatic coord_type shift(coord_type value, logic backward);
      coord_type result;
      if (backward) begin
         result = (value == '0) ? CoordWidth'(Side - 1) : value - 1'b1;
      end else begin
         result = (value == CoordWidth'(Side - 1)) ? '0 : value + 1'b1;
      end
      return result;
   endfunction

   logic                 s1_valid_ff, s1_valid_in;
   place_type            s1_first_ff, s1_second_ff;
   logic                 s1_last_ff;
   logic                 s2_valid_ff, s2_valid_in;
   logic                 s2_sel_ff, s2_sel_in;
   logic [CodeWidth-1:0] s2_first_ff, s2_second_ff;
   logic                 s2_last_ff;
   logic                 s2_take, s2_free, s1_move, s1_free;
   place_type            pa, pb;
   logic [CodeWidth-1:0] sub_first, sub_second;

   assign s2_take   = s2_valid_ff && s2_sel_ff && pop;
   assign s2_free   = !s2_valid_ff || s2_take;
   assign s1_move   = s1_valid_ff && s2_free;
   assign s1_free   = !s1_valid_ff || s1_move;
   assign queue_pop = !queue_empty && s1_free;

   // Same row (including a letter paired with itself), same column, or rectangle.
   always_comb begin
      pa = s1_first_ff;
      pb = s1_second_ff;
      if (s1_first_ff.row == s1_second_ff.row) begin
         pa.col = shift(s1_first_ff.col, decrypt_mode);
         pb.col = shift(s1_second_ff.col, decrypt_mode);
      end else if (s1_first_ff.col == s1_second_ff.col) begin
         pa.row = shift(s1_first_ff.row, decrypt_mode);
         pb.row = shift(s1_second_ff.row, decrypt_mode);
      end else begin
         pa.col = s1_second_ff.col;
         pb.col = s1_first_ff.col;
      end
      sub_first  = key_square[pa.row][pa.col];
      sub_second = key_square[pb.row][pb.col];
   end

   always_comb begin
      s1_valid_in = s1_free ? !queue_empty : s1_valid_ff;
      s2_valid_in = s2_valid_ff;
      s2_sel_in   = s2_sel_ff;
      if (s1_move) begin
         s2_valid_in = 1'b1;
         s2_sel_in   = 1'b0;
      end else if (s2_take) begin
         s2_valid_in = 1'b0;
      end else if (s2_valid_ff && pop) begin
         s2_sel_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s2_sel_ff   <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s2_sel_ff   <= s2_sel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (queue_pop) begin
         s1_first_ff  <= locate(key_square, head_job.first);
         s1_second_ff <= locate(key_square, head_job.second);
         s1_last_ff   <= head_job.last;
      end
      if (s1_move) begin
         s2_first_ff  <= sub_first;
         s2_second_ff <= sub_second;
         s2_last_ff   <= s1_last_ff;
      end
   end

   assign empty          = !s2_valid_ff;
   assign rsp_out_letter = s2_sel_ff ? s2_second_ff : s2_first_ff;
   assign rsp_run_end    = s2_sel_ff && s2_last_ff;

endmodule

@@ rtl/playfair_digraph_cipher_core.sv @@
// Top level of the Playfair digraph cipher core with its configuration registers.
//
// Requests enter on a queue-like port: a letter code (A=0..Z=25, J read as I) and a
// message_end flag are taken at a clock edge with push high and full low. Results
// leave the same way: while empty is low the oldest substituted letter and its
// run_end flag are shown, and pop takes it. Each digraph yields two letters;
// run_end marks the last letter caused by a request.
// The front end pairs letters and places digraphs in a job queue; the back end
// locates both letters and registers their places, then substitutes them and
// holds the two letters in an output register. A digraph passes the job queue,
// the place register and the output register before its first letter appears.
// The single-letter result port limits the flow: it shows the two letters of a
// digraph one at a time. Requests are taken every cycle while the job queue has
// room; a request that flushes two digraphs blocks the port until both are queued.
// When the receiver stalls, the output register holds its letter and the job queue
// fills, after which full rises. Synchronous reset empties every stage, drops any
// waiting letter and loads the alphabetic key square in encrypt mode.
// The key rows and mode sit at byte addresses 0 to 20; write them only while idle.
module playfair_digraph_cipher_core #(
   parameter int unsigned QueueDepth = pf_pkg::QueueDepth
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic [pf_pkg::CodeWidth-1:0]  req_letter,
   input  logic                          req_message_end,
   output logic                          empty,
   input  logic                          pop,
   output logic [pf_pkg::CodeWidth-1:0]  rsp_out_letter,
   output logic                          rsp_run_end,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [pf_pkg::AddrWidth-1:0]  paddr,
   input  logic [pf_pkg::DataWidth-1:0]  pwdata,
   output logic [pf_pkg::DataWidth-1:0]  prdata,
   output logic                          pready
);
   import pf_pkg::*;

   key_square_type key_ff, key_in;
   logic           decrypt_ff, decrypt_in;
   logic [2:0]     reg_index;
   logic           cfg_write;
   job_push_type   job_push;
   job_type        head_job;
   logic           queue_full, queue_empty, queue_pop;

   assign pready    = 1'b1;
   assign reg_index = paddr[AddrWidth-1:2];
   assign cfg_write = psel && penable && pwrite && pready;

   always_comb begin
      key_in     = key_ff;
      decrypt_in = decrypt_ff;
      if (cfg_write) begin
         unique case (reg_index)
            RegKeyRowZero:  key_in[0] = pwdata[Side*CodeWidth-1:0];
            RegKeyRowOne:   key_in[1] = pwdata[Side*CodeWidth-1:0];
            RegKeyRowTwo:   key_in[2] = pwdata[Side*CodeWidth-1:0];
            RegKeyRowThree: key_in[3] = pwdata[Side*CodeWidth-1:0];
            RegKeyRowFour:  key_in[4] = pwdata[Side*CodeWidth-1:0];
            RegDecryptMode: decrypt_in = pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         RegKeyRowZero:  prdata = DataWidth'(key_ff[0]);
         RegKeyRowOne:   prdata = DataWidth'(key_ff[1]);
         RegKeyRowTwo:   prdata = DataWidth'(key_ff[2]);
         RegKeyRowThree: prdata = DataWidth'(key_ff[3]);
         RegKeyRowFour:  prdata = DataWidth'(key_ff[4]);
         RegDecryptMode: prdata = DataWidth'(decrypt_ff);
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff     <= KeyReset;
         decrypt_ff <= 1'b0;
      end else begin
         key_ff     <= key_in;
         decrypt_ff <= decrypt_in;
      end
   end

   pf_front u_front (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_letter      (req_letter),
      .req_message_end (req_message_end),
      .job_push        (job_push),
      .queue_full      (queue_full)
   );

   pf_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .wr     (job_push),
      .full   (queue_full),
      .pop    (queue_pop),
      .rd_job (head_job),
      .empty  (queue_empty)
   );

   pf_back u_back (
      .clock          (clock),
      .reset          (reset),
      .key_square     (key_ff),
      .decrypt_mode   (decrypt_ff),
      .head_job       (head_job),
      .queue_empty    (queue_empty),
      .queue_pop      (queue_pop),
      .empty          (empty),
      .pop            (pop),
      .rsp_out_letter (rsp_out_letter),
      .rsp_run_end    (rsp_run_end)
   );

endmodule

@@ rtl/pf_checker.sv @@
// Port-level checks for the Playfair digraph cipher core, bound to the top level.
module pf_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          push,
   input logic                          full,
   input logic                          empty,
   input logic                          pop,
   input logic [pf_pkg::CodeWidth-1:0]  rsp_out_letter,
   input logic                          rsp_run_end,
   input logic                          pready
);
   import pf_pkg::*;

   // Reset leaves no result waiting and room for a request.
   a_reset_clears : assert property (@(posedge clock) reset |=> empty && !full)
      else $error("core not empty and ready after reset");

   // The request port can only fill up after a request was pushed.
   a_full_after_push : assert property (@(posedge clock) disable iff (reset)
      $rose(full) |-> $past(push))
      else $error("full rose without a request");

   // A stalled result stays on the ports unchanged.
   a_result_holds : assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_out_letter) && $stable(rsp_run_end))
      else $error("waiting result changed while stalled");

   // A result never appears straight out of reset.
   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      $fell(empty) |-> !$past(reset))
      else $error("result appeared straight out of reset");

   a_ready : assert property (@(posedge clock) disable iff (reset) pready)
      else $error("configuration port not ready");

endmodule

bind playfair_digraph_cipher_core pf_checker u_pf_checker (.*);
